// ===== rtl/interval_list_intersection_macros.svh =====
// Assertion helpers for the files that check themselves.
// Each macro samples on the rising edge of clk and is quiet while rst is high.
`ifndef INTERVAL_LIST_INTERSECTION_MACROS_SVH
`define INTERVAL_LIST_INTERSECTION_MACROS_SVH

// Same-cycle implication.
`define ILI_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ILI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ili_pkg.sv =====
`default_nettype none

package ili_pkg;

  localparam int unsigned B_DEPTH_DEF = 32;
  localparam int unsigned TIME_W      = 64;

  typedef logic signed [TIME_W-1:0] time_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD_B = 2'd1,
    CMD_PROC_A = 2'd2,
    CMD_FINISH = 2'd3
  } cmd_t;

  typedef enum logic {
    KIND_INTERVAL = 1'b0,
    KIND_STATUS   = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_A    = 3'd1,
    ST_BAD_B    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/ili_if.sv =====
`default_nettype none

interface ili_in_if;
  logic          valid;
  logic          ready;
  ili_pkg::cmd_t cmd;
  ili_pkg::time_t start_time;
  ili_pkg::time_t stop_time;

  modport source(output valid, output cmd, output start_time, output stop_time,
                 input ready);
  modport sink(input valid, input cmd, input start_time, input stop_time,
               output ready);
endinterface

interface ili_out_if;
  logic             valid;
  logic             ready;
  ili_pkg::kind_t   kind;
  ili_pkg::time_t   out_start;
  ili_pkg::time_t   out_stop;
  ili_pkg::status_t status;
  logic             last;

  modport source(output valid, output kind, output out_start, output out_stop,
                 output status, output last, input ready);
  modport sink(input valid, input kind, input out_start, input out_stop,
               input status, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/interval_list_intersection.sv =====
// Channel  Dir  Payload                                   Beat
// item     in   cmd, start_time, stop_time                one command
// res      out  kind, out_start, out_stop, status, last   one result
//
// Clear and load are done as they are accepted. Process walks the B store one entry per cycle
// while res does not stall, then flushes the held result; if B is empty it goes straight to the flush.
// Finish ends with a status beat; it walks B first only if no A was processed and B is not empty.
// A stall on res holds the walk; a finished result may wait in the output register.
// rst is synchronous: it clears the count, the flags and the sequencer. The B
// store is not cleared; only entries below the count are read.
`default_nettype none
`include "interval_list_intersection_macros.svh"

module interval_list_intersection #(
  parameter int unsigned B_DEPTH = ili_pkg::B_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst,
  ili_in_if.sink     item,
  ili_out_if.source  res
);

  localparam int unsigned CNT_W = $clog2(B_DEPTH + 1);
  localparam int unsigned IDX_W = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(B_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WALK  = 4'b0010,
    S_FLUSH = 4'b0100,
    S_STAT  = 4'b1000
  } state_t;

  state_t state, state_next;

  // B store, one synchronous memory per field.
  ili_pkg::time_t b_start_mem [B_DEPTH];
  ili_pkg::time_t b_stop_mem  [B_DEPTH];
  ili_pkg::time_t rd_start, rd_stop;

  logic [CNT_W-1:0] b_count;
  logic             a_seen, a_bad, b_bad, b_overflow;

  logic [CNT_W-1:0] rd_idx, rd_idx_next;
  logic             rd_pending, rd_pending_next;
  logic             rd_en;
  logic             fin;
  ili_pkg::time_t   a_start, a_stop;

  logic             hold_valid, hold_valid_next;
  ili_pkg::time_t   hold_start, hold_stop, hold_start_next, hold_stop_next;

  logic             out_valid;
  ili_pkg::kind_t   out_kind;
  ili_pkg::time_t   out_start, out_stop;
  ili_pkg::status_t out_status;
  logic             out_last;

  logic             push;
  ili_pkg::kind_t   push_kind;
  ili_pkg::time_t   push_start, push_stop;
  ili_pkg::status_t push_status;
  logic             push_last;

  logic             accept, out_free, is_full, wr_en;
  ili_pkg::time_t   lo, hi, cand_start, cand_stop;
  logic             cand_valid, issue, eval_done;
  ili_pkg::status_t status_now;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign out_free   = !out_valid || res.ready;
  assign is_full    = (b_count >= DEPTH_CNT);
  assign wr_en      = accept && (item.cmd == ili_pkg::CMD_LOAD_B) && !is_full;

  // Overlap of the held A interval with the most recently read B entry.
  assign lo         = (a_start < rd_start) ? rd_start : a_start;
  assign hi         = (rd_stop < a_stop) ? rd_stop : a_stop;
  assign cand_valid = fin ? 1'b1 : (lo < hi);
  assign cand_start = fin ? rd_start : lo;
  assign cand_stop  = fin ? rd_stop : hi;
  assign issue      = (rd_idx < b_count);

  // A candidate can retire when there is none, it is empty, the hold slot is free, or the
  // held result can move into the output register this cycle.
  assign eval_done  = !rd_pending || !cand_valid || !hold_valid || out_free;

  always_comb begin
    priority if (a_bad) begin
      status_now = ili_pkg::ST_BAD_A;
    end else if (b_bad) begin
      status_now = ili_pkg::ST_BAD_B;
    end else if (b_overflow) begin
      status_now = ili_pkg::ST_OVERFLOW;
    end else if (!a_seen && (b_count == '0)) begin
      status_now = ili_pkg::ST_EMPTY;
    end else begin
      status_now = ili_pkg::ST_OK;
    end
  end

  always_comb begin
    state_next      = state;
    rd_idx_next     = rd_idx;
    rd_pending_next = rd_pending;
    rd_en           = 1'b0;
    hold_valid_next = hold_valid;
    hold_start_next = hold_start;
    hold_stop_next  = hold_stop;
    push            = 1'b0;
    push_kind       = ili_pkg::KIND_INTERVAL;
    push_start      = hold_start;
    push_stop       = hold_stop;
    push_status     = ili_pkg::ST_OK;
    push_last       = 1'b0;

    unique case (state)
      S_IDLE: begin
        rd_idx_next     = '0;
        rd_pending_next = 1'b0;
        if (accept) begin
          unique case (item.cmd)
            ili_pkg::CMD_PROC_A: begin
              if (b_count == '0) begin
                // No B stored: the A interval passes through.
                hold_valid_next = 1'b1;
                hold_start_next = item.start_time;
                hold_stop_next  = item.stop_time;
                state_next      = S_FLUSH;
              end else begin
                state_next = S_WALK;
              end
            end
            ili_pkg::CMD_FINISH: begin
              state_next = (!a_seen && (b_count != '0)) ? S_WALK : S_STAT;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end

      S_WALK: begin
        if (rd_pending && cand_valid && eval_done) begin
          if (hold_valid) begin
            push = 1'b1;
          end
          hold_valid_next = 1'b1;
          hold_start_next = cand_start;
          hold_stop_next  = cand_stop;
        end
        if (eval_done) begin
          if (issue) begin
            rd_en           = 1'b1;
            rd_idx_next     = rd_idx + CNT_W'(1);
            rd_pending_next = 1'b1;
          end else begin
            rd_pending_next = 1'b0;
            if (!rd_pending) begin
              state_next = S_FLUSH;
            end
          end
        end
      end

      S_FLUSH: begin
        if (!hold_valid) begin
          state_next = fin ? S_STAT : S_IDLE;
        end else if (out_free) begin
          push            = 1'b1;
          push_last       = !fin;
          hold_valid_next = 1'b0;
          state_next      = fin ? S_STAT : S_IDLE;
        end
      end

      S_STAT: begin
        if (out_free) begin
          push        = 1'b1;
          push_kind   = ili_pkg::KIND_STATUS;
          push_start  = '0;
          push_stop   = '0;
          push_status = status_now;
          push_last   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      b_start_mem[b_count[IDX_W-1:0]] <= item.start_time;
      b_stop_mem[b_count[IDX_W-1:0]]  <= item.stop_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_start <= b_start_mem[rd_idx[IDX_W-1:0]];
      rd_stop  <= b_stop_mem[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_count    <= '0;
      a_seen     <= 1'b0;
      a_bad      <= 1'b0;
      b_bad      <= 1'b0;
      b_overflow <= 1'b0;
    end else if (accept) begin
      unique case (item.cmd)
        ili_pkg::CMD_CLEAR: begin
          b_count    <= '0;
          a_seen     <= 1'b0;
          a_bad      <= 1'b0;
          b_bad      <= 1'b0;
          b_overflow <= 1'b0;
        end
        ili_pkg::CMD_LOAD_B: begin
          if (is_full) begin
            b_overflow <= 1'b1;
          end else begin
            b_count <= b_count + CNT_W'(1);
            if (item.stop_time < item.start_time) begin
              b_bad <= 1'b1;
            end
          end
        end
        ili_pkg::CMD_PROC_A: begin
          a_seen <= 1'b1;
          if (item.stop_time < item.start_time) begin
            a_bad <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_start <= item.start_time;
      a_stop  <= item.stop_time;
    end
    hold_start <= hold_start_next;
    hold_stop  <= hold_stop_next;
    rd_idx     <= rd_idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rd_pending <= 1'b0;
      hold_valid <= 1'b0;
      fin        <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_pending_next;
      hold_valid <= hold_valid_next;
      if (accept) begin
        fin <= (item.cmd == ili_pkg::CMD_FINISH);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind   <= push_kind;
      out_start  <= push_start;
      out_stop   <= push_stop;
      out_status <= push_status;
      out_last   <= push_last;
    end
  end

  assign res.valid     = out_valid;
  assign res.kind      = out_kind;
  assign res.out_start = out_start;
  assign res.out_stop  = out_stop;
  assign res.status    = out_status;
  assign res.last      = out_last;

  `ILI_ASSERT(a_count_range, 1'b1, b_count <= DEPTH_CNT, "B count beyond store depth")
  `ILI_ASSERT(a_idle_clean, item.ready, !rd_pending && !hold_valid, "ready with work in flight")
  `ILI_ASSERT(a_status_last, res.valid && (res.kind == ili_pkg::KIND_STATUS), res.last, "status beat without last")
  `ILI_ASSERT_NEXT(a_overflow_set, accept && (item.cmd == ili_pkg::CMD_LOAD_B) && is_full, b_overflow, "full load did not flag overflow")

endmodule

`default_nettype wire
